/* rtl/aicd_pkg.sv */
// Package for the ARM instruction class decoder: the class mask/match tables,
// the condition code names and the condition evaluation function.
// Depends on nothing; every other file refers to it by scoped names.
package aicd_pkg;

	localparam int unsigned CLASS_COUNT = 64;
	localparam int unsigned CLASS_IDX_W = $clog2(CLASS_COUNT);

	typedef logic [31:0]            word_t;
	typedef logic [CLASS_IDX_W-1:0] class_idx_t;

	// Condition field codes, bits 31..28 of the instruction
	typedef enum logic [3:0] {
		COND_EQ = 4'd0,
		COND_NE = 4'd1,
		COND_CS = 4'd2,
		COND_CC = 4'd3,
		COND_MI = 4'd4,
		COND_PL = 4'd5,
		COND_VS = 4'd6,
		COND_VC = 4'd7,
		COND_HI = 4'd8,
		COND_LS = 4'd9,
		COND_GE = 4'd10,
		COND_LT = 4'd11,
		COND_GT = 4'd12,
		COND_LE = 4'd13,
		COND_AL = 4'd14,
		COND_NV = 4'd15
	} cond_t;

	// Class table: entry k hits when (word & CLASS_MASK[k]) == CLASS_MATCH[k]
	localparam word_t CLASS_MASK [CLASS_COUNT] = '{
		32'h0fe000f0, 32'h0fe000f0, 32'h0ff00090, 32'h0fe000f0,
		32'h0ff00090, 32'h0ff000b0, 32'h0fe000f0, 32'h0ff000b0,
		32'h0ff00090, 32'h0fe000f0, 32'h0fe000f0, 32'h0ff00000,
		32'h0ff000f0, 32'h0ff000f0, 32'h0fb00000, 32'h0fb000f0,
		32'h0fb00000, 32'h0e000000, 32'h0ff000f0, 32'hfe000000,
		32'h0ff000f0, 32'h0d700000, 32'h0c500000, 32'h0d700000,
		32'h0c500000, 32'h0e1000f0, 32'h0e1000f0, 32'h0e1000f0,
		32'h0e1000f0, 32'h0e500000, 32'h0e708000, 32'h0d700000,
		32'h0c500000, 32'h0d700000, 32'h0c500000, 32'h0e1000f0,
		32'h0e1000f0, 32'h0e500000, 32'h0e700000, 32'h0de00000,
		32'h0de00000, 32'h0de00000, 32'h0de00000, 32'h0de00000,
		32'h0de00000, 32'h0de00000, 32'h0de00000, 32'h0df00000,
		32'h0df00000, 32'h0df00000, 32'h0df00000, 32'h0de00000,
		32'h0de00000, 32'h0de00000, 32'h0de00000, 32'hfff000f0,
		32'h0f000000, 32'h0f000010, 32'h0ff00000, 32'h0e100000,
		32'h0f100010, 32'h0ff00000, 32'h0f100010, 32'h0e100000
	};

	localparam word_t CLASS_MATCH [CLASS_COUNT] = '{
		32'h00200090, 32'h00000090, 32'h01000080, 32'h00e00090,
		32'h01400080, 32'h01200080, 32'h00c00090, 32'h012000a0,
		32'h01600080, 32'h00a00090, 32'h00800090, 32'h01600000,
		32'h01000090, 32'h01400090, 32'h01000000, 32'h01200000,
		32'h03200000, 32'h0a000000, 32'h01200010, 32'hfa000000,
		32'h01200030, 32'h04300000, 32'h04100000, 32'h04700000,
		32'h04500000, 32'h000000d0, 32'h001000b0, 32'h001000d0,
		32'h001000f0, 32'h08100000, 32'h08500000, 32'h04200000,
		32'h04000000, 32'h04600000, 32'h04400000, 32'h000000f0,
		32'h000000b0, 32'h08000000, 32'h08400000, 32'h00000000,
		32'h00200000, 32'h00400000, 32'h00600000, 32'h00800000,
		32'h00a00000, 32'h00c00000, 32'h00e00000, 32'h01100000,
		32'h01300000, 32'h01500000, 32'h01700000, 32'h01800000,
		32'h01a00000, 32'h01c00000, 32'h01e00000, 32'he1200070,
		32'h0f000000, 32'h0e000000, 32'h0c500000, 32'h0c100000,
		32'h0e000010, 32'h0c400000, 32'h0e100010, 32'h0c000000
	};

	// Evaluate a condition code against N, Z, C, V; the never code fails
	function automatic logic cond_eval(cond_t code, logic n, logic z, logic c, logic v);
		logic pass;
		case (code)
			COND_EQ: pass = z;
			COND_NE: pass = !z;
			COND_CS: pass = c;
			COND_CC: pass = !c;
			COND_MI: pass = n;
			COND_PL: pass = !n;
			COND_VS: pass = v;
			COND_VC: pass = !v;
			COND_HI: pass = c && !z;
			COND_LS: pass = !c || z;
			COND_GE: pass = (n == v);
			COND_LT: pass = (n != v);
			COND_GT: pass = !z && (n == v);
			COND_LE: pass = z || (n != v);
			COND_AL: pass = 1'b1;
			COND_NV: pass = 1'b0;
			default: pass = 1'b0;
		endcase
		return pass;
	endfunction

endpackage

/* rtl/aicd_if.sv */
// Channel interfaces of the ARM instruction class decoder: instruction in,
// classification result out, each with valid/ready. Depends on aicd_pkg.
interface aicd_in_if;
	logic               valid;
	logic               ready;
	aicd_pkg::word_t    instruction_word;
	logic               flag_n;
	logic               flag_z;
	logic               flag_c;
	logic               flag_v;

	modport source (
		output valid, instruction_word, flag_n, flag_z, flag_c, flag_v,
		input  ready
	);
	modport sink (
		input  valid, instruction_word, flag_n, flag_z, flag_c, flag_v,
		output ready
	);
endinterface

interface aicd_out_if;
	logic                  valid;
	logic                  ready;
	aicd_pkg::class_idx_t  class_index;
	logic                  class_found;
	logic                  cond_pass;

	modport source (
		output valid, class_index, class_found, cond_pass,
		input  ready
	);
	modport sink (
		input  valid, class_index, class_found, cond_pass,
		output ready
	);
endinterface

/* rtl/arm_instruction_class_decode.sv */
// Pipeline: an input transfer loads the input register, which feeds the table compare
// and condition check; these load the result register, which offers the result. A stalled
// output holds the result register and can hold the input register behind it.
// Throughput: one instruction per cycle unless the output stalls; all 64 class compares
// run in parallel and a priority encoder picks the lowest hit, so no loop limits the rate.
// Reset: arst_n clears both stage valid bits; payload registers are not reset.
// Depends on aicd_pkg and the channel interfaces in aicd_if.sv.
module arm_instruction_class_decode (
	input  logic       clk,
	input  logic       arst_n,
	aicd_in_if.sink    insn,
	aicd_out_if.source result
);

	// Stage 1: registered instruction and flags
	logic                 valid_s1;
	aicd_pkg::word_t      word_s1;
	logic                 n_s1, z_s1, c_s1, v_s1;

	// Stage 2: registered classification result
	logic                 valid_s2;
	aicd_pkg::class_idx_t idx_s2;
	logic                 found_s2;
	logic                 pass_s2;

	logic                 adv_s2;
	logic                 adv_s1;

	logic [aicd_pkg::CLASS_COUNT-1:0] hit;
	aicd_pkg::class_idx_t             idx_d;
	logic                             found_d;
	logic                             pass_d;
	aicd_pkg::cond_t                  cond_d;

	// Handshake: stage 2 takes a new result when empty or being drained
	assign adv_s2     = !valid_s2 || result.ready;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign insn.ready = adv_s1;

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= insn.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && insn.valid) begin
			word_s1 <= insn.instruction_word;
			n_s1    <= insn.flag_n;
			z_s1    <= insn.flag_z;
			c_s1    <= insn.flag_c;
			v_s1    <= insn.flag_v;
		end
	end

	// Compare the word against every class entry in parallel
	always_comb begin
		for (int k = 0; k < aicd_pkg::CLASS_COUNT; k++) begin
			hit[k] = ((word_s1 & aicd_pkg::CLASS_MASK[k]) == aicd_pkg::CLASS_MATCH[k]);
		end
	end

	// Pick the lowest-numbered hit
	always_comb begin
		idx_d   = '0;
		found_d = 1'b0;
		for (int k = aicd_pkg::CLASS_COUNT - 1; k >= 0; k--) begin
			if (hit[k]) begin
				idx_d   = aicd_pkg::CLASS_IDX_W'(k);
				found_d = 1'b1;
			end
		end
	end

	// Check the condition field against the flags
	assign cond_d = aicd_pkg::cond_t'(word_s1[31:28]);
	assign pass_d = aicd_pkg::cond_eval(cond_d, n_s1, z_s1, c_s1, v_s1);

	// Hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			idx_s2   <= idx_d;
			found_s2 <= found_d;
			pass_s2  <= pass_d;
		end
	end

	assign result.valid       = valid_s2;
	assign result.class_index = idx_s2;
	assign result.class_found = found_s2;
	assign result.cond_pass   = pass_s2;

	// A full pipe with a stalled output must refuse new input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result.ready |-> !insn.ready)
		else $error("input accepted while both stages are full and stalled");

	// An input transfer always lands in stage 1
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		insn.valid && insn.ready |=> valid_s1)
		else $error("accepted instruction lost before stage 1");

	// A reported class really matches its table entry
	a_hit_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && found_d |->
		((word_s1 & aicd_pkg::CLASS_MASK[idx_d]) == aicd_pkg::CLASS_MATCH[idx_d]))
		else $error("reported class does not match the instruction");

	// No class found means index zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.class_found |-> result.class_index == '0)
		else $error("nonzero class index without a match");

	// The never condition code never passes
	a_never_fails: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && cond_d == aicd_pkg::COND_NV |-> !pass_d)
		else $error("never condition reported as passing");

endmodule
